// File: rtl/core/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h68;
	localparam logic [7:0] TAIL_BYTE = 8'h16;
	localparam logic [7:0] OVERHEAD = 8'd5;
	localparam logic [7:0] MAX_LEN_RESET = 8'(9'd256 - {1'b0, OVERHEAD});

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CTRL = 3'd1,
		PH_LEN  = 3'd2,
		PH_BODY = 3'd3,
		PH_SUM  = 3'd4,
		PH_TAIL = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_PENDING  = 3'd0,
		ST_GOOD     = 3'd1,
		ST_BAD_LEN  = 3'd2,
		ST_BAD_SUM  = 3'd3,
		ST_BAD_TAIL = 3'd4
	} status_t;

	typedef enum logic {
		REG_CHECK_EN = 1'b0,
		REG_MAX_LEN  = 1'b1
	} reg_index_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  body_cnt;
		logic [7:0]  length;
		logic [7:0]  sum;
		logic [7:0]  control;
		logic [7:0]  source;
		logic [7:0]  destination;
		logic [15:0] command;
	} frame_state_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        in_frame;
		logic [7:0]  position;
		status_t     status;
		logic [7:0]  frame_control;
		logic [7:0]  frame_length;
		logic [7:0]  frame_source;
		logic [7:0]  frame_destination;
		logic [15:0] frame_command;
	} result_t;

	typedef struct packed {
		logic       check_en;
		logic [7:0] max_len;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/sfd_if.sv
`default_nettype none

interface sfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface sfd_report_if;
	logic             valid;
	logic             ready;
	logic [7:0]       byte_out;
	logic             in_frame;
	logic [7:0]       position;
	logic [2:0]       status;
	logic [7:0]       frame_control;
	logic [7:0]       frame_length;
	logic [7:0]       frame_source;
	logic [7:0]       frame_destination;
	logic [15:0]      frame_command;

	modport source (
		output valid, output byte_out, output in_frame, output position, output status,
		output frame_control, output frame_length, output frame_source,
		output frame_destination, output frame_command, input ready
	);
	modport sink (
		input valid, input byte_out, input in_frame, input position, input status,
		input frame_control, input frame_length, input frame_source,
		input frame_destination, input frame_command, output ready
	);
endinterface

`default_nettype wire

// File: rtl/core/sum_checked_frame_deframer.sv
// Channel  | Direction | Word
// rx       | in        | byte_in, one received byte
// report   | out       | byte_out, in_frame, position, status and captured frame fields
// cfg_*    | in        | register write: cfg_we, cfg_index, cfg_wdata
//
// One byte enters per cycle unless the report stalls; the report word is registered.
// The frame state updates when a byte moves from the input register to the report register.
// arst_n clears the frame state to hunting and loads the register reset values.
// A stalled report holds; the input register still takes one more byte behind it.
`default_nettype none

module sum_checked_frame_deframer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sfd_rx_if.sink          rx,
	sfd_report_if.source    report,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_wdata
);

	sfd_pkg::cfg_t         cfg_q;
	sfd_pkg::frame_state_t state_q;
	sfd_pkg::frame_state_t state_nxt;
	sfd_pkg::result_t      res_nxt;
	sfd_pkg::result_t      res_s2;
	logic [7:0]            byte_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  advance;

	assign advance = valid_s1 && (!valid_s2 || report.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_en <= 1'b1;
			cfg_q.max_len <= sfd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (sfd_pkg::reg_index_t'(cfg_index))
				sfd_pkg::REG_CHECK_EN: cfg_q.check_en <= cfg_wdata[0];
				sfd_pkg::REG_MAX_LEN: cfg_q.max_len <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.byte_in;
		end
	end

	sfd_parse u_parse (
		.cur(state_q),
		.cfg(cfg_q),
		.rx_byte(byte_s1),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (report.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign report.valid = valid_s2;
	assign report.byte_out = res_s2.byte_out;
	assign report.in_frame = res_s2.in_frame;
	assign report.position = res_s2.position;
	assign report.status = res_s2.status;
	assign report.frame_control = res_s2.frame_control;
	assign report.frame_length = res_s2.frame_length;
	assign report.frame_source = res_s2.frame_source;
	assign report.frame_destination = res_s2.frame_destination;
	assign report.frame_command = res_s2.frame_command;

endmodule

`default_nettype wire

// File: rtl/core/sfd_parse.sv
`default_nettype none

module sfd_parse (
	input  wire sfd_pkg::frame_state_t cur,
	input  wire sfd_pkg::cfg_t         cfg,
	input  wire logic [7:0]            rx_byte,
	output sfd_pkg::frame_state_t      nxt,
	output sfd_pkg::result_t           res
);

	sfd_pkg::frame_state_t upd;
	sfd_pkg::frame_state_t hunt;
	sfd_pkg::status_t      status;
	logic                  infr;
	logic [8:0]            pos;
	logic [7:0]            body_next;

	always_comb begin
		hunt = '0;
		hunt.phase = sfd_pkg::PH_HUNT;
		if (rx_byte == sfd_pkg::HDR_BYTE) begin
			hunt.phase = sfd_pkg::PH_CTRL;
			hunt.sum = sfd_pkg::HDR_BYTE;
		end
	end

	assign body_next = cur.body_cnt + 8'd1;

	always_comb begin
		upd = cur;
		status = sfd_pkg::ST_PENDING;
		infr = 1'b1;
		pos = '0;
		unique case (cur.phase)
			sfd_pkg::PH_CTRL: begin
				pos = 9'd1;
				upd.control = rx_byte;
				upd.sum = cur.sum + rx_byte;
				upd.phase = sfd_pkg::PH_LEN;
			end
			sfd_pkg::PH_LEN: begin
				pos = 9'd2;
				upd.length = rx_byte;
				if (rx_byte > cfg.max_len) begin
					status = sfd_pkg::ST_BAD_LEN;
				end else begin
					upd.sum = cur.sum + rx_byte;
					upd.body_cnt = '0;
					upd.phase = (rx_byte == 8'd0) ? sfd_pkg::PH_SUM : sfd_pkg::PH_BODY;
				end
			end
			sfd_pkg::PH_BODY: begin
				pos = {1'b0, cur.body_cnt} + 9'd3;
				unique case (cur.body_cnt)
					8'd0: upd.source = rx_byte;
					8'd1: upd.destination = rx_byte;
					8'd2: upd.command[15:8] = rx_byte;
					8'd3: upd.command[7:0] = rx_byte;
					default: ;
				endcase
				upd.sum = cur.sum + rx_byte;
				upd.body_cnt = body_next;
				if (body_next >= cur.length) begin
					upd.phase = sfd_pkg::PH_SUM;
				end
			end
			sfd_pkg::PH_SUM: begin
				pos = {1'b0, cur.length} + 9'd3;
				if (cfg.check_en && (rx_byte != cur.sum)) begin
					status = sfd_pkg::ST_BAD_SUM;
				end else begin
					upd.phase = sfd_pkg::PH_TAIL;
				end
			end
			sfd_pkg::PH_TAIL: begin
				pos = {1'b0, cur.length} + 9'd4;
				status = (rx_byte == sfd_pkg::TAIL_BYTE) ? sfd_pkg::ST_GOOD
					: sfd_pkg::ST_BAD_TAIL;
			end
			default: begin
				upd = hunt;
				infr = (rx_byte == sfd_pkg::HDR_BYTE);
			end
		endcase
	end

	always_comb begin
		res = '0;
		res.byte_out = rx_byte;
		res.in_frame = infr;
		res.position = pos[8] ? 8'hFF : pos[7:0];
		res.status = status;
		nxt = upd;
		if (status != sfd_pkg::ST_PENDING) begin
			res.frame_control = upd.control;
			res.frame_length = upd.length;
			res.frame_source = upd.source;
			res.frame_destination = upd.destination;
			res.frame_command = upd.command;
			nxt = hunt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sfd_checker.sv
`default_nettype none

module sfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  byte_out,
	input wire logic        in_frame,
	input wire logic [7:0]  position,
	input wire logic [2:0]  status,
	input wire logic [7:0]  frame_control,
	input wire logic [7:0]  frame_length,
	input wire logic [7:0]  frame_source,
	input wire logic [7:0]  frame_destination,
	input wire logic [15:0] frame_command
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(status)
			&& $stable(position))
		else $error("report word changed while stalled");

	a_error_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 3'(sfd_pkg::ST_PENDING)) |-> in_frame)
		else $error("frame end reported outside a frame");

	a_pending_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 3'(sfd_pkg::ST_PENDING)) |-> (frame_control == 8'd0)
			&& (frame_length == 8'd0) && (frame_source == 8'd0)
			&& (frame_destination == 8'd0) && (frame_command == 16'd0))
		else $error("captured fields shown on a pending word");

	a_hunt_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_frame |-> (position == 8'd0)
			&& (status == 3'(sfd_pkg::ST_PENDING)))
		else $error("byte outside a frame has a position or status");

	a_good_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 3'(sfd_pkg::ST_GOOD)) |-> (byte_out == sfd_pkg::TAIL_BYTE)
			&& (position == ((frame_length > 8'd251) ? 8'hFF : frame_length + 8'd4)))
		else $error("good frame ended on a wrong tail byte or position");

endmodule

bind sum_checked_frame_deframer sfd_checker u_sfd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(report.valid),
	.out_ready(report.ready),
	.byte_out(report.byte_out),
	.in_frame(report.in_frame),
	.position(report.position),
	.status(report.status),
	.frame_control(report.frame_control),
	.frame_length(report.frame_length),
	.frame_source(report.frame_source),
	.frame_destination(report.frame_destination),
	.frame_command(report.frame_command)
);

`default_nettype wire
